// File: rtl/cll_pkg.sv
// ----------------------------------------------------------------------------
// cll_pkg
// Shared constants for the circular list manager: pool size, field widths
// and command codes.
// ----------------------------------------------------------------------------
package cll_pkg;

    // Node pool
    localparam int MAX_NODES = 64;
    localparam int ADDR_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    // Field widths of the stream payloads
    localparam int CMD_W     = 3;
    localparam int NODE_ID_W = 6;
    localparam int COUNT_W   = 7;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR         = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_TAIL      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADD_CURSOR    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE        = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INSERT_CURSOR = 3'd4;

endpackage

// File: rtl/cll_ram.sv
// ----------------------------------------------------------------------------
// cll_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/circular_list_with_cursor.sv
// ----------------------------------------------------------------------------
// circular_list_with_cursor
// Round-robin circular doubly linked list over a fixed pool of node ids.
// ----------------------------------------------------------------------------
// One command is taken per transaction: clear, add at the tail (before the
// head), add before the cursor, remove a node, or insert before the cursor
// and make the new node the cursor. The next and prev links live in two RAMs
// with one write and one registered read port each; the linked bits, head,
// cursor and count are flip-flops. A command passes through the RAM read at
// acceptance, the execute state and the result load; an add into a non-empty
// list also passes through a second link state, because its four link
// updates do not all fit on the two single write ports at once. s_tready
// returns in the cycle after the result is loaded, even while that result
// still waits on m_tready, so a new command is taken only once the last
// one's result is loaded; a second finished result waits until the first is
// taken.
// ----------------------------------------------------------------------------
module circular_list_with_cursor
    import cll_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [2:0] cmd, [8:3] node_id, [15:9] zero
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [0] ok, [7:1] count, [13:8] first_node,
                                   // [19:14] cursor_node, [20] is_empty,
                                   // [23:21] zero
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LINK2,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_REJECT,
        OP_CLEAR,
        OP_SOLE,
        OP_LINK,
        OP_UNLINK
    } op_t;

    typedef struct packed {
        logic                 is_empty;
        logic [NODE_ID_W-1:0] cursor_node;
        logic [NODE_ID_W-1:0] first_node;
        logic [COUNT_W-1:0]   count;
        logic                 ok;
    } result_t;

    state_t               state_reg;
    op_t                  op_reg;
    logic [NODE_ID_W-1:0] node_reg;
    logic [NODE_ID_W-1:0] at_reg;
    logic [NODE_ID_W-1:0] pv_reg;
    logic                 ins_reg;

    logic [MAX_NODES-1:0] linked_reg;
    logic [NODE_ID_W-1:0] head_reg;
    logic [NODE_ID_W-1:0] cursor_reg;
    logic [COUNT_W-1:0]   count_reg;

    logic                 m_tvalid_reg;
    result_t              result_reg;
    logic                 result_load;

    // Input fields
    logic [CMD_W-1:0]     in_cmd;
    logic [NODE_ID_W-1:0] in_node;
    logic                 in_pool;
    logic                 in_linked;
    logic                 is_add;
    op_t                  in_op;
    logic [NODE_ID_W-1:0] in_at;

    // RAM ports
    logic                 nx_we;
    logic [ADDR_W-1:0]    nx_waddr;
    logic [NODE_ID_W-1:0] nx_wdata;
    logic [NODE_ID_W-1:0] nx_rdata;
    logic                 pv_we;
    logic [ADDR_W-1:0]    pv_waddr;
    logic [NODE_ID_W-1:0] pv_wdata;
    logic [NODE_ID_W-1:0] pv_rdata;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 accept;

    assign in_cmd    = s_tdata[CMD_W-1:0];
    assign in_node   = s_tdata[CMD_W +: NODE_ID_W];
    assign in_pool   = 32'(in_node) < MAX_NODES;
    assign in_linked = linked_reg[ADDR_W'(in_node)];
    assign is_add    = (in_cmd == CMD_ADD_TAIL) || (in_cmd == CMD_ADD_CURSOR)
                    || (in_cmd == CMD_INSERT_CURSOR);
    assign in_at     = (in_cmd == CMD_ADD_TAIL) ? head_reg : cursor_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Load the result when the output register is free or being emptied
    assign result_load = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    // Classify the command against the current list state
    always_comb begin
        in_op = OP_REJECT;
        if (in_cmd == CMD_CLEAR) begin
            in_op = OP_CLEAR;
        end else if (is_add) begin
            if (in_pool && !in_linked) begin
                in_op = (count_reg == '0) ? OP_SOLE : OP_LINK;
            end
        end else if (in_cmd == CMD_REMOVE) begin
            if (in_pool && in_linked) begin
                in_op = OP_UNLINK;
            end
        end
    end

    // Read the removed node's links, or the anchor's prev link for an add
    assign rd_addr = (in_cmd == CMD_REMOVE) ? ADDR_W'(in_node) : ADDR_W'(in_at);

    // Link write-back
    always_comb begin
        nx_we    = 1'b0;
        nx_waddr = ADDR_W'(node_reg);
        nx_wdata = node_reg;
        pv_we    = 1'b0;
        pv_waddr = ADDR_W'(node_reg);
        pv_wdata = node_reg;
        case (state_reg)
            S_EXEC: begin
                case (op_reg)
                    OP_SOLE: begin
                        nx_we = 1'b1;
                        pv_we = 1'b1;
                    end
                    OP_LINK: begin
                        // next[n] = anchor, prev[anchor] = n
                        nx_we    = 1'b1;
                        nx_wdata = at_reg;
                        pv_we    = 1'b1;
                        pv_waddr = ADDR_W'(at_reg);
                    end
                    OP_UNLINK: begin
                        // next[pv] = nx, prev[nx] = pv
                        if (count_reg > COUNT_W'(1)) begin
                            nx_we    = 1'b1;
                            nx_waddr = ADDR_W'(pv_rdata);
                            nx_wdata = nx_rdata;
                            pv_we    = 1'b1;
                            pv_waddr = ADDR_W'(nx_rdata);
                            pv_wdata = pv_rdata;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_LINK2: begin
                // next[p] = n, prev[n] = p
                nx_we    = 1'b1;
                nx_waddr = ADDR_W'(pv_reg);
                pv_we    = 1'b1;
                pv_wdata = pv_reg;
            end
            default: begin
            end
        endcase
    end

    cll_ram #(
        .WIDTH(NODE_ID_W),
        .DEPTH(MAX_NODES)
    ) u_next_ram (
        .clk  (aclk),
        .we   (nx_we),
        .waddr(nx_waddr),
        .wdata(nx_wdata),
        .raddr(rd_addr),
        .rdata(nx_rdata)
    );

    cll_ram #(
        .WIDTH(NODE_ID_W),
        .DEPTH(MAX_NODES)
    ) u_prev_ram (
        .clk  (aclk),
        .we   (pv_we),
        .waddr(pv_waddr),
        .wdata(pv_wdata),
        .raddr(rd_addr),
        .rdata(pv_rdata)
    );

    // Sequencer, list registers and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            op_reg       <= OP_REJECT;
            linked_reg   <= '0;
            head_reg     <= '0;
            cursor_reg   <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // Raise valid on a load, drop it once the result is taken
            if (result_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        op_reg    <= in_op;
                        node_reg  <= in_node;
                        at_reg    <= in_at;
                        ins_reg   <= (in_cmd == CMD_INSERT_CURSOR);
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    state_reg <= S_DONE;
                    case (op_reg)
                        OP_CLEAR: begin
                            linked_reg <= '0;
                            head_reg   <= '0;
                            cursor_reg <= '0;
                            count_reg  <= '0;
                        end
                        OP_SOLE: begin
                            linked_reg[ADDR_W'(node_reg)] <= 1'b1;
                            head_reg   <= node_reg;
                            cursor_reg <= node_reg;
                            count_reg  <= COUNT_W'(1);
                        end
                        OP_LINK: begin
                            linked_reg[ADDR_W'(node_reg)] <= 1'b1;
                            count_reg <= count_reg + COUNT_W'(1);
                            if (ins_reg) begin
                                cursor_reg <= node_reg;
                            end
                            pv_reg    <= pv_rdata;
                            state_reg <= S_LINK2;
                        end
                        OP_UNLINK: begin
                            linked_reg[ADDR_W'(node_reg)] <= 1'b0;
                            if (count_reg <= COUNT_W'(1)) begin
                                head_reg   <= '0;
                                cursor_reg <= '0;
                                count_reg  <= '0;
                            end else begin
                                // Advance head or cursor past the removed node
                                if (head_reg == node_reg) begin
                                    head_reg <= nx_rdata;
                                end
                                if (cursor_reg == node_reg) begin
                                    cursor_reg <= nx_rdata;
                                end
                                count_reg <= count_reg - COUNT_W'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_LINK2: begin
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    // Load the result when the output register is free
                    if (result_load) begin
                        result_reg.ok          <= (op_reg != OP_REJECT);
                        result_reg.count       <= count_reg;
                        result_reg.first_node  <= head_reg;
                        result_reg.cursor_node <= cursor_reg;
                        result_reg.is_empty    <= (count_reg == '0);
                        state_reg              <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, result_reg};

    // An empty list reports head and cursor as zero
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (head_reg == '0) && (cursor_reg == '0))
        else $error("empty list with nonzero head or cursor");

    // The count tracks the number of linked nodes
    a_count_linked: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(linked_reg) == int'(count_reg))
        else $error("count disagrees with linked bits");

    // Head and cursor point at linked nodes between commands
    a_ends_linked: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) && (count_reg != '0) |->
            linked_reg[ADDR_W'(head_reg)] && linked_reg[ADDR_W'(cursor_reg)])
        else $error("head or cursor not linked");

endmodule
